@@ sv/simcc_kpd_pkg.sv @@
// ----------------------------------------------------------------------------
// simcc_kpd_pkg
// Shared types and constants for the SimCC keypoint decode unit.
// ----------------------------------------------------------------------------
package simcc_kpd_pkg;

	localparam int KP_COUNT_DEF = 21;
	localparam int ROW_LEN_DEF  = 256;

	localparam int PROB_W    = 16;
	localparam int COEF_W    = 32;
	localparam int RATIO_W   = 16;
	localparam int KP_IDX_W  = 5;
	localparam int COORD_W   = 16;
	localparam int POS_MAX_W = 10;
	localparam int SCALED_W  = POS_MAX_W + RATIO_W;
	localparam int ACC_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FRAC_SH   = 14;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_SPLIT_RATIO = 3'd0,
		REG_COEF_X_FROM_X   = 3'd1,
		REG_COEF_X_FROM_Y   = 3'd2,
		REG_OFFSET_X        = 3'd3,
		REG_COEF_Y_FROM_X   = 3'd4,
		REG_COEF_Y_FROM_Y   = 3'd5,
		REG_OFFSET_Y        = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic        [RATIO_W-1:0] inv_split_ratio;
		logic signed [COEF_W-1:0]  coef_x_from_x;
		logic signed [COEF_W-1:0]  coef_x_from_y;
		logic signed [COEF_W-1:0]  offset_x;
		logic signed [COEF_W-1:0]  coef_y_from_x;
		logic signed [COEF_W-1:0]  coef_y_from_y;
		logic signed [COEF_W-1:0]  offset_y;
	} cfg_t;

	typedef struct packed {
		logic [KP_IDX_W-1:0]  kp_idx;
		logic [POS_MAX_W-1:0] pos_x;
		logic [POS_MAX_W-1:0] pos_y;
		logic [PROB_W-1:0]    score;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCALE,
		BK_MUL,
		BK_DRAIN,
		BK_ROUND
	} back_state_t;

endpackage

@@ sv/simcc_kpd_front.sv @@
// ----------------------------------------------------------------------------
// simcc_kpd_front
// Running argmax over the x and y rows; emits one job per keypoint.
// ----------------------------------------------------------------------------
module simcc_kpd_front
	import simcc_kpd_pkg::*;
#(
	parameter int KP_COUNT = KP_COUNT_DEF,
	parameter int ROW_LEN  = ROW_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PROB_W-1:0] x_prob,
	input  logic [PROB_W-1:0] y_prob,
	input  logic              x_present,
	input  logic              y_present,
	input  logic              row_last,
	input  logic              q_full,
	output logic              push,
	output job_t              push_job
);

	localparam int CNT_W  = $clog2(ROW_LEN + 1);
	localparam int POS_W  = $clog2(ROW_LEN);
	localparam int KP_W   = (KP_COUNT > 1) ? $clog2(KP_COUNT) : 1;
	localparam int KPX_W  = (KP_W > KP_IDX_W) ? KP_W : KP_IDX_W;

	logic [PROB_W-1:0] bx_q, by_q, nbx, nby;
	logic [POS_W-1:0]  px_q, py_q, npx, npy;
	logic [CNT_W-1:0]  cx_q, cy_q, ncx, ncy;
	logic [KP_W-1:0]   kp_q;
	logic [KPX_W-1:0]  kp_ext;
	logic              accept;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;
	assign kp_ext   = KPX_W'(kp_q);

	always_comb begin
		nbx = bx_q;
		npx = px_q;
		ncx = cx_q;
		nby = by_q;
		npy = py_q;
		ncy = cy_q;
		if (x_present && (cx_q < CNT_W'(ROW_LEN))) begin
			if (x_prob > bx_q) begin
				nbx = x_prob;
				npx = cx_q[POS_W-1:0];
			end
			ncx = cx_q + 1'b1;
		end
		if (y_present && (cy_q < CNT_W'(ROW_LEN))) begin
			if (y_prob > by_q) begin
				nby = y_prob;
				npy = cy_q[POS_W-1:0];
			end
			ncy = cy_q + 1'b1;
		end
	end

	assign push            = accept & row_last;
	assign push_job.kp_idx = kp_ext[KP_IDX_W-1:0];
	assign push_job.pos_x  = POS_MAX_W'(npx);
	assign push_job.pos_y  = POS_MAX_W'(npy);
	assign push_job.score  = (nbx > nby) ? nbx : nby;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bx_q <= '0;
			by_q <= '0;
			px_q <= '0;
			py_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			kp_q <= '0;
		end else if (accept) begin
			if (row_last) begin
				bx_q <= '0;
				by_q <= '0;
				px_q <= '0;
				py_q <= '0;
				cx_q <= '0;
				cy_q <= '0;
				if (kp_q == KP_W'(KP_COUNT - 1)) begin
					kp_q <= '0;
				end else begin
					kp_q <= kp_q + 1'b1;
				end
			end else begin
				bx_q <= nbx;
				by_q <= nby;
				px_q <= npx;
				py_q <= npy;
				cx_q <= ncx;
				cy_q <= ncy;
			end
		end
	end

endmodule

@@ sv/simcc_kpd_queue.sv @@
// ----------------------------------------------------------------------------
// simcc_kpd_queue
// Two-entry job queue between the argmax front and the coordinate back.
// ----------------------------------------------------------------------------
module simcc_kpd_queue
	import simcc_kpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output job_t q_job
);

	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/simcc_kpd_back.sv @@
// ----------------------------------------------------------------------------
// simcc_kpd_back
// Scales argmax positions, applies the affine map with one shared
// multiplier, rounds half to even, saturates and holds the result.
// ----------------------------------------------------------------------------
module simcc_kpd_back
	import simcc_kpd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      q_valid,
	input  job_t                      q_job,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [KP_IDX_W-1:0]       keypoint_index,
	output logic signed [COORD_W-1:0] point_x,
	output logic signed [COORD_W-1:0] point_y,
	output logic [PROB_W-1:0]         score
);

	localparam int PROD_W = COEF_W + SCALED_W + 1;
	localparam logic [1:0] LAST_STEP = 2'd3;

	function automatic logic [COORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-31:0] q;
		logic [29:0]              r;
		logic                     up;
		logic signed [ACC_W-30:0] qr;
		q  = v[ACC_W-1:30];
		r  = v[29:0];
		up = (r > 30'h2000_0000) || ((r == 30'h2000_0000) && q[0]);
		qr = $signed({q[ACC_W-31], q}) + $signed({{(ACC_W-30){1'b0}}, up});
		if (qr > $signed((ACC_W-29)'(32767))) begin
			round_sat = 16'h7FFF;
		end else if (qr < -$signed((ACC_W-29)'(32768))) begin
			round_sat = 16'h8000;
		end else begin
			round_sat = qr[COORD_W-1:0];
		end
	endfunction

	back_state_t              state_q, state_d;
	job_t                     job_q;
	logic [SCALED_W-1:0]      px_q, py_q;
	logic [1:0]               step_q;
	logic signed [ACC_W-1:0]  acc_x_q, acc_y_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     prod_y_s1;
	logic                     prod_vld_s1;
	logic                     load_out;
	logic                     out_valid_q;
	logic signed [COEF_W-1:0] mul_coef;
	logic [SCALED_W-1:0]      mul_p;
	logic signed [ACC_W-1:0]  prod_ext;

	assign out_valid = out_valid_q;
	assign prod_ext  = ACC_W'(prod_s1);

	always_comb begin
		unique case (step_q)
			2'd0: begin
				mul_coef = cfg.coef_x_from_x;
				mul_p    = px_q;
			end
			2'd1: begin
				mul_coef = cfg.coef_x_from_y;
				mul_p    = py_q;
			end
			2'd2: begin
				mul_coef = cfg.coef_y_from_x;
				mul_p    = px_q;
			end
			default: begin
				mul_coef = cfg.coef_y_from_y;
				mul_p    = py_q;
			end
		endcase
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = BK_SCALE;
				end
			end
			BK_SCALE: state_d = BK_MUL;
			BK_MUL: begin
				if (step_q == LAST_STEP) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: state_d = BK_ROUND;
			BK_ROUND: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			step_q      <= '0;
			prod_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			prod_vld_s1 <= (state_q == BK_MUL);
			if (state_q == BK_SCALE) begin
				step_q <= '0;
			end else if (state_q == BK_MUL) begin
				step_q <= step_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (state_q == BK_SCALE) begin
			px_q    <= SCALED_W'(job_q.pos_x) * SCALED_W'(cfg.inv_split_ratio);
			py_q    <= SCALED_W'(job_q.pos_y) * SCALED_W'(cfg.inv_split_ratio);
			acc_x_q <= ACC_W'(cfg.offset_x) <<< FRAC_SH;
			acc_y_q <= ACC_W'(cfg.offset_y) <<< FRAC_SH;
		end else if (prod_vld_s1) begin
			if (prod_y_s1) begin
				acc_y_q <= acc_y_q + prod_ext;
			end else begin
				acc_x_q <= acc_x_q + prod_ext;
			end
		end
		if (state_q == BK_MUL) begin
			prod_s1   <= mul_coef * $signed({1'b0, mul_p});
			prod_y_s1 <= step_q[1];
		end
		if (load_out) begin
			keypoint_index <= job_q.kp_idx;
			point_x        <= round_sat(acc_x_q);
			point_y        <= round_sat(acc_y_q);
			score          <= job_q.score;
		end
	end

endmodule

@@ sv/simcc_keypoint_decode_unit.sv @@
// ----------------------------------------------------------------------------
// simcc_keypoint_decode_unit
// SimCC keypoint decoder: running argmax over x and y probability rows,
// then scale, affine map, round half to even and saturate per keypoint.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one row position per item:
// optional x and y probabilities and a row_last flag closing the keypoint.
// Output channel (out_valid / out_stall) carries one result per keypoint:
// its index, the image point and the larger of the two row maxima.
// The front takes one item per cycle unless the queue is full. On row_last it
// posts a job to a two-entry queue; the back takes one job at a time (pop,
// scale, four passes of one 32x27 multiplier, drain, round) and registers
// the result. Rows at least as long as the back's job time stream at one
// item per cycle while the queue is not full; shorter rows are paced by the
// back's job time. in_stall rises only while the queue is full. When the
// receiver stalls, the result register holds, the back waits in its round
// step and then the queue fills. Reset clears the trackers, the keypoint
// counter, the queue and the output valid, and loads the register defaults
// (ratio one half, identity map). Write registers only while idle.
// ----------------------------------------------------------------------------
module simcc_keypoint_decode_unit
	import simcc_kpd_pkg::*;
#(
	parameter int KP_COUNT = KP_COUNT_DEF,
	parameter int ROW_LEN  = ROW_LEN_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [PROB_W-1:0]         x_prob,
	input  logic [PROB_W-1:0]         y_prob,
	input  logic                      x_present,
	input  logic                      y_present,
	input  logic                      row_last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [KP_IDX_W-1:0]       keypoint_index,
	output logic signed [COORD_W-1:0] point_x,
	output logic signed [COORD_W-1:0] point_y,
	output logic [PROB_W-1:0]         score
);

	cfg_t cfg_q;
	logic push, q_full, pop, q_valid;
	job_t push_job, q_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_split_ratio <= 16'd8192;
			cfg_q.coef_x_from_x   <= 32'sd65536;
			cfg_q.coef_x_from_y   <= '0;
			cfg_q.offset_x        <= '0;
			cfg_q.coef_y_from_x   <= '0;
			cfg_q.coef_y_from_y   <= 32'sd65536;
			cfg_q.offset_y        <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INV_SPLIT_RATIO: cfg_q.inv_split_ratio <= cfg_data[RATIO_W-1:0];
				REG_COEF_X_FROM_X:   cfg_q.coef_x_from_x   <= cfg_data;
				REG_COEF_X_FROM_Y:   cfg_q.coef_x_from_y   <= cfg_data;
				REG_OFFSET_X:        cfg_q.offset_x        <= cfg_data;
				REG_COEF_Y_FROM_X:   cfg_q.coef_y_from_x   <= cfg_data;
				REG_COEF_Y_FROM_Y:   cfg_q.coef_y_from_y   <= cfg_data;
				REG_OFFSET_Y:        cfg_q.offset_y        <= cfg_data;
				default: ;
			endcase
		end
	end

	simcc_kpd_front #(
		.KP_COUNT(KP_COUNT),
		.ROW_LEN (ROW_LEN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.x_prob   (x_prob),
		.y_prob   (y_prob),
		.x_present(x_present),
		.y_present(y_present),
		.row_last (row_last),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	simcc_kpd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_job   (q_job)
	);

	simcc_kpd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_job         (q_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.keypoint_index(keypoint_index),
		.point_x       (point_x),
		.point_y       (point_y),
		.score         (score)
	);

endmodule
